@@ sv/table_driven_dfa_recognizer_unit_defines.svh @@
// Assertion macros for the DFA recognizer.
`ifndef TABLE_DRIVEN_DFA_RECOGNIZER_UNIT_DEFINES_SVH
`define TABLE_DRIVEN_DFA_RECOGNIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define TDR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tdr assertion failed");

// Next-cycle implication, disabled in reset.
`define TDR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tdr assertion failed");

`endif

@@ sv/tdr_pkg.sv @@
// Shared types and constants of the DFA recognizer.
`default_nettype none
package tdr_pkg;

  localparam int STATE_W     = 8;
  localparam int CNT_W       = 9;
  localparam int CHAR_W      = 8;
  localparam int CHARS       = 256;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_CLASS  = 2'd0,
    OP_TRANS  = 2'd1,
    OP_ACCEPT = 2'd2,
    OP_CHAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT = 2'd0,
    VERDICT_REJECT = 2'd1,
    VERDICT_WRONG  = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASS,
    ST_TRANS,
    ST_ACC,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    op_e                op;
    logic [CHAR_W-1:0]  char_code;
    logic [CHAR_W-1:0]  symbol_index;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic               entry_valid;
    logic               last_char;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } back_stat_t;

endpackage
`default_nettype wire

@@ sv/tdr_if.sv @@
// Request and result channel interfaces of the DFA recognizer.
`default_nettype none
interface tdr_in_if;
  import tdr_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [CHAR_W-1:0]  char_code;
  logic [CHAR_W-1:0]  symbol_index;
  logic [STATE_W-1:0] from_state;
  logic [STATE_W-1:0] to_state;
  logic               entry_valid;
  logic               last_char;

  modport source (output valid, func, char_code, symbol_index, from_state, to_state,
                  entry_valid, last_char, input ready);
  modport sink (input valid, func, char_code, symbol_index, from_state, to_state,
                entry_valid, last_char, output ready);
endinterface

interface tdr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface
`default_nettype wire

@@ sv/tdr_front.sv @@
// Front end: decodes requests and drops out-of-range table writes.
`default_nettype none
module tdr_front #(
  parameter int STATES  = 256,
  parameter int SYMBOLS = 256
) (
  tdr_in_if.sink          in_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output tdr_pkg::cmd_t   push_data_o
);
  import tdr_pkg::*;

  localparam logic [CNT_W-1:0] ST_LIM = CNT_W'(STATES);
  localparam logic [CNT_W-1:0] SY_LIM = CNT_W'(SYMBOLS);

  op_e  op;
  logic from_ok;
  logic sym_ok;
  logic keep;

  assign op      = op_e'(in_i.func);
  assign from_ok = {1'b0, in_i.from_state} < ST_LIM;
  assign sym_ok  = {1'b0, in_i.symbol_index} < SY_LIM;

  always_comb begin
    case (op)
      OP_CLASS:  keep = sym_ok;
      OP_TRANS:  keep = from_ok && sym_ok;
      OP_ACCEPT: keep = from_ok;
      OP_CHAR:   keep = 1'b1;
      default:   keep = 1'b0;
    endcase
  end

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid && keep;

  assign push_data_o.op           = op;
  assign push_data_o.char_code    = in_i.char_code;
  assign push_data_o.symbol_index = in_i.symbol_index;
  assign push_data_o.from_state   = in_i.from_state;
  assign push_data_o.to_state     = in_i.to_state;
  assign push_data_o.entry_valid  = in_i.entry_valid;
  assign push_data_o.last_char    = in_i.last_char;

endmodule
`default_nettype wire

@@ sv/tdr_queue.sv @@
// Short command queue between front and back end.
`default_nettype none
module tdr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  tdr_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output tdr_pkg::cmd_t pop_data_o
);
  import tdr_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              push;
  logic              pop;

  assign push_ready_o = cnt_q != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

@@ sv/tdr_back.sv @@
// Back end: table memories, automaton run and result register.
`default_nettype none
module tdr_back #(
  parameter int STATES  = 256,
  parameter int SYMBOLS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  tdr_pkg::cmd_t               cmd_i,
  input  logic [tdr_pkg::STATE_W-1:0] start_state_i,
  input  logic [tdr_pkg::CNT_W-1:0]   state_count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tdr_pkg::verdict_e           out_verdict_o,
  output tdr_pkg::back_stat_t         stat_o
);
  import tdr_pkg::*;

  localparam int SW     = $clog2(STATES);
  localparam int YW     = $clog2(SYMBOLS);
  localparam int TW     = SW + YW;
  localparam int TDEPTH = 1 << TW;
  localparam int ADEPTH = 1 << SW;
  localparam logic [CNT_W-1:0] ST_LIM = CNT_W'(STATES);

  // Memories
  logic [YW:0]      class_mem [CHARS];
  logic [CHARS-1:0] class_wr_q;
  logic [YW:0]      class_rd_q;
  logic             class_hit_q;
  logic [STATE_W:0] trans_mem [TDEPTH];
  logic [STATE_W:0] trans_rd_q;
  logic             acc_mem [ADEPTH];
  logic [ADEPTH-1:0] acc_wr_q;
  logic             acc_rd_q;
  logic             acc_hit_q;

  // Control and run state
  back_state_e        state_q, state_d;
  logic [STATE_W-1:0] cur_q, cur_d;
  logic               wrong_q, wrong_d;
  logic               dead_q, dead_d;
  logic               in_str_q, in_str_d;
  logic               last_q, last_d;
  verdict_e           verdict_q, verdict_d;
  logic               out_valid_q, out_valid_d;
  verdict_e           out_verdict_q;
  logic               clr_busy_q;
  logic [TW-1:0]      clr_addr_q;

  logic               pop;
  logic               class_we, trans_we, acc_we, char_go;
  logic [STATE_W-1:0] st;
  logic               cls_ok;
  logic               te_ok;
  logic               cur_lt;
  back_state_e        fin_state;
  logic [TW-1:0]      trans_raddr;
  logic [TW-1:0]      trans_waddr;
  logic [SW-1:0]      acc_raddr;
  logic               out_load;

  assign cmd_ready_o = (state_q == ST_IDLE) && !clr_busy_q;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign class_we    = pop && (cmd_i.op == OP_CLASS);
  assign trans_we    = pop && (cmd_i.op == OP_TRANS);
  assign acc_we      = pop && (cmd_i.op == OP_ACCEPT);
  assign char_go     = pop && (cmd_i.op == OP_CHAR);

  assign st          = in_str_q ? cur_q : start_state_i;
  assign cls_ok      = class_hit_q && class_rd_q[YW];
  assign te_ok       = trans_rd_q[STATE_W] &&
                       ({1'b0, trans_rd_q[STATE_W-1:0]} < state_count_i);
  assign cur_lt      = {1'b0, cur_q} < ST_LIM;
  assign fin_state   = last_q ? ST_ACC : ST_IDLE;
  assign trans_raddr = {st[SW-1:0], class_rd_q[YW-1:0]};
  assign trans_waddr = {cmd_i.from_state[SW-1:0], cmd_i.symbol_index[YW-1:0]};
  assign acc_raddr   = cur_d[SW-1:0];

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    wrong_d   = wrong_q;
    dead_d    = dead_q;
    in_str_d  = in_str_q;
    last_d    = last_q;
    verdict_d = verdict_q;
    case (state_q)
      ST_IDLE: begin
        if (char_go) begin
          state_d = ST_CLASS;
          last_d  = cmd_i.last_char;
        end
      end
      ST_CLASS: begin
        in_str_d = 1'b1;
        cur_d    = st;
        if (!cls_ok) begin
          wrong_d = 1'b1;
          state_d = fin_state;
        end else if (wrong_q || dead_q) begin
          state_d = fin_state;
        end else if ({1'b0, st} >= ST_LIM) begin
          dead_d  = 1'b1;
          state_d = fin_state;
        end else begin
          state_d = ST_TRANS;
        end
      end
      ST_TRANS: begin
        if (te_ok) begin
          cur_d = trans_rd_q[STATE_W-1:0];
        end else begin
          dead_d = 1'b1;
        end
        state_d = fin_state;
      end
      ST_ACC: begin
        if (wrong_q) begin
          verdict_d = VERDICT_WRONG;
        end else if (dead_q) begin
          verdict_d = VERDICT_REJECT;
        end else if (cur_lt && acc_hit_q && acc_rd_q) begin
          verdict_d = VERDICT_ACCEPT;
        end else begin
          verdict_d = VERDICT_REJECT;
        end
        in_str_d = 1'b0;
        wrong_d  = 1'b0;
        dead_d   = 1'b0;
        cur_d    = start_state_i;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_load    = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cur_q         <= '0;
      wrong_q       <= 1'b0;
      dead_q        <= 1'b0;
      in_str_q      <= 1'b0;
      last_q        <= 1'b0;
      verdict_q     <= VERDICT_REJECT;
      out_valid_q   <= 1'b0;
      out_verdict_q <= VERDICT_REJECT;
      clr_busy_q    <= 1'b1;
      clr_addr_q    <= '0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      wrong_q     <= wrong_d;
      dead_q      <= dead_d;
      in_str_q    <= in_str_d;
      last_q      <= last_d;
      verdict_q   <= verdict_d;
      out_valid_q <= out_valid_d;
      if (out_load) begin
        out_verdict_q <= verdict_q;
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + TW'(1);
        if (clr_addr_q == '1) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  // Written flags stand in for a reset of the small tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_wr_q <= '0;
      acc_wr_q   <= '0;
    end else begin
      if (class_we) begin
        class_wr_q[cmd_i.char_code] <= 1'b1;
      end
      if (acc_we) begin
        acc_wr_q[cmd_i.from_state[SW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (class_we) begin
      class_mem[cmd_i.char_code] <= {cmd_i.entry_valid, cmd_i.symbol_index[YW-1:0]};
    end
    class_rd_q  <= class_mem[cmd_i.char_code];
    class_hit_q <= class_wr_q[cmd_i.char_code];
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      trans_mem[clr_addr_q] <= '0;
    end else if (trans_we) begin
      trans_mem[trans_waddr] <= {cmd_i.entry_valid, cmd_i.to_state};
    end
    trans_rd_q <= trans_mem[trans_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[cmd_i.from_state[SW-1:0]] <= cmd_i.entry_valid;
    end
    acc_rd_q  <= acc_mem[acc_raddr];
    acc_hit_q <= acc_wr_q[acc_raddr];
  end

  assign out_valid_o    = out_valid_q;
  assign out_verdict_o  = out_verdict_q;
  assign stat_o.clearing = clr_busy_q;
  assign stat_o.idle     = state_q == ST_IDLE;

endmodule
`default_nettype wire

@@ sv/table_driven_dfa_recognizer_unit.sv @@
// Top level of the table-driven DFA recognizer.
// Requests enter a decoder and a two-entry queue; the back end runs them one at a time.
// A table write is taken in the idle state. A character passes queue pop, class map
// read and transition read, and skips the transition read when its class entry is
// invalid, the current state is out of range or the string is already decided. The last
// character of a string adds the accept flag read and the result load, and it waits
// while the result register is still held. The dependent class-then-transition memory
// read loop limits the character rate. After reset the transition memory is cleared,
// one entry a cycle, through all 2**(clog2(STATES)+clog2(SYMBOLS)) entries (65536 at
// the defaults); requests wait, and configuration writes are taken throughout. One verdict
// comes out per string, on its last character: 0 accepted, 1 rejected, 2 wrong symbol.
`default_nettype none
`include "table_driven_dfa_recognizer_unit_defines.svh"
module table_driven_dfa_recognizer_unit #(
  parameter int STATES  = 256,
  parameter int SYMBOLS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tdr_in_if.sink                         in_i,
  tdr_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [tdr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tdr_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import tdr_pkg::*;

  logic [STATE_W-1:0] start_q;
  logic [CNT_W-1:0]   count_q;

  logic       f_valid, f_ready;
  cmd_t       f_data;
  logic       q_valid, q_ready;
  cmd_t       q_data;
  logic       q_pop;
  logic       b_out_valid;
  verdict_e   b_verdict;
  back_stat_t b_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      count_q <= CNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_STATE: start_q <= cfg_wdata_i[STATE_W-1:0];
        CFG_STATE_COUNT: count_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  tdr_front #(
    .STATES  (STATES),
    .SYMBOLS (SYMBOLS)
  ) u_front (
    .in_i         (in_i),
    .push_valid_o (f_valid),
    .push_ready_i (f_ready),
    .push_data_o  (f_data)
  );

  tdr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  tdr_back #(
    .STATES  (STATES),
    .SYMBOLS (SYMBOLS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_ready_o   (q_ready),
    .cmd_i         (q_data),
    .start_state_i (start_q),
    .state_count_i (count_q),
    .out_valid_o   (b_out_valid),
    .out_ready_i   (out_o.ready),
    .out_verdict_o (b_verdict),
    .stat_o        (b_stat)
  );

  assign out_o.valid   = b_out_valid;
  assign out_o.verdict = b_verdict;
  assign q_pop         = q_valid && q_ready;

  `TDR_ASSERT_IMPL(a_no_pop_clear, clk_i, rst_ni, b_stat.clearing, !q_pop)
  `TDR_ASSERT_IMPL(a_no_out_clear, clk_i, rst_ni, b_stat.clearing, !out_o.valid)
  `TDR_ASSERT_NEXT(a_char_runs, clk_i, rst_ni, q_pop && (q_data.op == OP_CHAR), !b_stat.idle)

endmodule
`default_nettype wire
